/* src/coap_response_classifier_assert.svh */
// Assertion macros for the CoAP response classifier.
// Used by coap_response_classifier.sv; needs nothing else.
`ifndef COAP_RESPONSE_CLASSIFIER_ASSERT_SVH
`define COAP_RESPONSE_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define CRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// Consequent must hold in the cycle after the antecedent.
`define CRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define CRC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/coap_rc_pkg.sv */
// Shared types and constants for the CoAP response classifier.
// No dependencies; imported by coap_rc_classify, coap_response_classifier and the testbench.
package coap_rc_pkg;

    localparam int TOKEN_BYTES = 8;
    localparam int TOKEN_W     = 8 * TOKEN_BYTES;
    localparam int TOKEN_LEN_W = 4;
    localparam int MSG_ID_W    = 16;
    localparam int MSG_CODE_W  = 8;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [1:0] {
        TYPE_CON = 2'd0,
        TYPE_NON = 2'd1,
        TYPE_ACK = 2'd2,
        TYPE_RST = 2'd3
    } t_msg_type;

    typedef enum logic [2:0] {
        ACT_IGNORE       = 3'd0,
        ACT_SEPARATED    = 3'd1,
        ACT_RESPONSE     = 3'd2,
        ACT_RESET        = 3'd3,
        ACT_ACK_ONLY     = 3'd4,
        ACT_RESPONSE_ACK = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        REG_REQUEST_ID         = 2'd0,
        REG_EXPECTED_TOKEN     = 2'd1,
        REG_EXPECTED_TOKEN_LEN = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_msg_type               msg_type;
        logic [MSG_CODE_W-1:0]   code;
        logic [MSG_ID_W-1:0]     id;
        logic [TOKEN_W-1:0]      token;
        logic [TOKEN_LEN_W-1:0]  token_len;
    } t_msg;

    typedef struct packed {
        t_action action;
        logic    set_separate;
        logic    take_id;
    } t_verdict;

endpackage

/* src/coap_rc_classify.sv */
// Combinational classification of one message header against the request.
// Depends on coap_rc_pkg.
module coap_rc_classify (
    input  coap_rc_pkg::t_msg                          i_msg,
    input  logic [coap_rc_pkg::MSG_ID_W-1:0]           i_request_id,
    input  logic [coap_rc_pkg::TOKEN_W-1:0]            i_exp_token,
    input  logic [coap_rc_pkg::TOKEN_LEN_W-1:0]        i_exp_len,
    input  logic                                       i_dedup_valid,
    input  logic [coap_rc_pkg::MSG_ID_W-1:0]           i_dedup_id,
    output coap_rc_pkg::t_verdict                      o_verdict
);
    import coap_rc_pkg::*;

    logic [TOKEN_BYTES-1:0] byte_ok;
    logic                   tok_match;
    logic                   id_match;

    // Bytes at or above the expected length are don't-care.
    for (genvar g = 0; g < TOKEN_BYTES; g++) begin : g_byte
        assign byte_ok[g] = (i_msg.token[8*g +: 8] == i_exp_token[8*g +: 8])
                         || (TOKEN_LEN_W'(g) >= i_exp_len);
    end

    assign tok_match = (i_msg.token_len == i_exp_len) && (&byte_ok);
    assign id_match  = (i_msg.id == i_request_id);

    always_comb begin
        o_verdict = '{action: ACT_IGNORE, set_separate: 1'b0, take_id: 1'b0};
        case (i_msg.msg_type)
            TYPE_ACK: begin
                if (id_match) begin
                    if (i_msg.code == '0) begin
                        o_verdict.action       = ACT_SEPARATED;
                        o_verdict.set_separate = 1'b1;
                    end else if (tok_match) begin
                        o_verdict.action = ACT_RESPONSE;
                    end
                end
            end
            TYPE_RST: begin
                if (id_match) begin
                    o_verdict.action = ACT_RESET;
                end
            end
            TYPE_CON: begin
                if (!tok_match) begin
                    o_verdict.action = ACT_ACK_ONLY;
                end else if (i_dedup_valid && (i_dedup_id == i_msg.id)) begin
                    o_verdict.action = ACT_ACK_ONLY;
                end else begin
                    o_verdict.action  = ACT_RESPONSE_ACK;
                    o_verdict.take_id = 1'b1;
                end
            end
            TYPE_NON: begin
                if (tok_match) begin
                    o_verdict.action = ACT_RESPONSE;
                end
            end
            default: begin
                o_verdict.action = ACT_IGNORE;
            end
        endcase
    end

endmodule

/* src/coap_response_classifier.sv */
// CoAP response classifier: classifies received message headers against one
// outstanding request. A request is registered in the input stage on acceptance,
// classified, and its result and the dedup and separate-response marks are
// registered as it advances to the result stage. One request per clock is sustained
// while the receiver is ready; the dedup-ID register update is the loop that sets
// that figure. The output register lets a new request enter while a result waits.
// Writes to the three configuration registers take effect at once and clear both marks.
// Depends on coap_rc_pkg, coap_rc_classify and coap_response_classifier_assert.svh.
`include "coap_response_classifier_assert.svh"

module coap_response_classifier (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [1:0]                              i_cfg_index,
    input  logic [coap_rc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [1:0]                              i_msg_type,
    input  logic [coap_rc_pkg::MSG_CODE_W-1:0]      i_msg_code,
    input  logic [coap_rc_pkg::MSG_ID_W-1:0]        i_msg_id,
    input  logic [coap_rc_pkg::TOKEN_W-1:0]         i_msg_token,
    input  logic [coap_rc_pkg::TOKEN_LEN_W-1:0]     i_msg_token_len,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [2:0]                              o_action,
    output logic                                    o_separate_pending
);
    import coap_rc_pkg::*;

    logic [MSG_ID_W-1:0]    r_request_id;
    logic [TOKEN_W-1:0]     r_exp_token;
    logic [TOKEN_LEN_W-1:0] r_exp_len;
    logic [TOKEN_LEN_W-1:0] n_exp_len_clamped;
    logic                   r_dedup_valid;
    logic [MSG_ID_W-1:0]    r_dedup_id;
    logic                   r_sep_seen;
    logic                   n_sep_seen;

    logic                   r_in_valid;
    t_msg                   r_in;
    logic                   r_out_valid;
    t_action                r_action;
    logic                   r_sep_out;

    logic                   in_acc;
    logic                   advance;
    logic                   cfg_clear;
    t_verdict               verdict;

    assign in_acc  = i_valid && o_ready;
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    assign cfg_clear = i_cfg_we && ((i_cfg_index == REG_REQUEST_ID)
                                 || (i_cfg_index == REG_EXPECTED_TOKEN)
                                 || (i_cfg_index == REG_EXPECTED_TOKEN_LEN));

    // Clamp the length write to the token capacity.
    assign n_exp_len_clamped = (i_cfg_data[TOKEN_LEN_W-1:0] > TOKEN_LEN_W'(TOKEN_BYTES))
                             ? TOKEN_LEN_W'(TOKEN_BYTES) : i_cfg_data[TOKEN_LEN_W-1:0];

    coap_rc_classify u_classify (
        .i_msg         (r_in),
        .i_request_id  (r_request_id),
        .i_exp_token   (r_exp_token),
        .i_exp_len     (r_exp_len),
        .i_dedup_valid (r_dedup_valid),
        .i_dedup_id    (r_dedup_id),
        .o_verdict     (verdict)
    );

    assign n_sep_seen = r_sep_seen || (advance && verdict.set_separate);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_request_id <= '0;
            r_exp_token  <= '0;
            r_exp_len    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_REQUEST_ID:         r_request_id <= i_cfg_data[MSG_ID_W-1:0];
                REG_EXPECTED_TOKEN:     r_exp_token  <= i_cfg_data[TOKEN_W-1:0];
                REG_EXPECTED_TOKEN_LEN: r_exp_len    <= n_exp_len_clamped;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // Marks; a configuration write wins over an update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dedup_valid <= 1'b0;
            r_dedup_id    <= '0;
            r_sep_seen    <= 1'b0;
        end else if (cfg_clear) begin
            r_dedup_valid <= 1'b0;
            r_dedup_id    <= '0;
            r_sep_seen    <= 1'b0;
        end else begin
            r_sep_seen <= n_sep_seen;
            if (advance && verdict.take_id) begin
                r_dedup_valid <= 1'b1;
                r_dedup_id    <= r_in.id;
            end
        end
    end

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.msg_type  <= t_msg_type'(i_msg_type);
            r_in.code      <= i_msg_code;
            r_in.id        <= i_msg_id;
            r_in.token     <= i_msg_token;
            r_in.token_len <= i_msg_token_len;
        end
    end

    // Result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_action  <= verdict.action;
            r_sep_out <= n_sep_seen;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_action           = r_action;
    assign o_separate_pending = r_sep_out;

    `CRC_ASSERT_NOW(a_len_clamped, i_clk, i_rst_n, 1'b1, r_exp_len <= TOKEN_LEN_W'(TOKEN_BYTES))
    `CRC_ASSERT_NEXT(a_cfg_clears_marks, i_clk, i_rst_n, cfg_clear, !r_dedup_valid && !r_sep_seen)
    `CRC_ASSERT_NEXT(a_dedup_taken, i_clk, i_rst_n, advance && !cfg_clear && (verdict.action == ACT_RESPONSE_ACK), r_dedup_valid && (r_dedup_id == $past(r_in.id)))
    `CRC_ASSERT_NOW(a_separated_marks, i_clk, i_rst_n, o_valid && (o_action == ACT_SEPARATED), o_separate_pending)

endmodule

/* tb/sv/coap_response_classifier_tb.sv */
// Self-checking testbench for coap_response_classifier: directed and random requests
// are checked against an in-bench classifier. Needs coap_rc_pkg and the block's RTL.
module coap_response_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import coap_rc_pkg::*;

    localparam logic [1:0] REG_NONE   = 2'd3;   // index with no register behind it
    localparam logic [7:0] CODE_EMPTY = 8'd0;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 75;

    typedef struct packed {
        t_action action;
        logic    separate;
    } t_class;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [1:0]             i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [1:0]             i_msg_type = '0;
    logic [MSG_CODE_W-1:0]  i_msg_code = '0;
    logic [MSG_ID_W-1:0]    i_msg_id = '0;
    logic [TOKEN_W-1:0]     i_msg_token = '0;
    logic [TOKEN_LEN_W-1:0] i_msg_token_len = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [2:0]             o_action;
    logic                   o_separate_pending;

    coap_response_classifier uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_msg_type         (i_msg_type),
        .i_msg_code         (i_msg_code),
        .i_msg_id           (i_msg_id),
        .i_msg_token        (i_msg_token),
        .i_msg_token_len    (i_msg_token_len),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_action           (o_action),
        .o_separate_pending (o_separate_pending)
    );

    // classifier state as the block should hold it
    logic [15:0] cfg_req_id = '0;
    logic [63:0] cfg_token = '0;
    logic [3:0]  cfg_token_len = '0;
    logic [15:0] last_con_id = '0;
    logic        last_con_ok = 1'b0;
    logic        sep_seen = 1'b0;

    t_msg   msg_q[$];
    t_class class_q[$];
    t_msg   cur_msg = '0;
    bit     have_item = 1'b0;
    bit     calm = 1'b0;
    int     src_gap = 0;
    int     sink_gap = 0;
    int     hold_ask = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     stuck = 0;
    int     errors = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] len_mask(input logic [3:0] n);
        if (n >= TOKEN_BYTES)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic bit token_hit(input logic [63:0] tok, input logic [3:0] len);
        if (len != cfg_token_len)
            return 1'b0;
        return ((tok ^ cfg_token) & len_mask(cfg_token_len)) == 64'd0;
    endfunction

    // classify one request and advance the dedup and separate marks
    function automatic t_class classify_msg(input t_msg m);
        t_class c;
        c.action = ACT_IGNORE;
        case (m.msg_type)
            TYPE_ACK: begin
                if (m.id == cfg_req_id) begin
                    if (m.code == CODE_EMPTY) begin
                        sep_seen = 1'b1;
                        c.action = ACT_SEPARATED;
                    end else if (token_hit(m.token, m.token_len)) begin
                        c.action = ACT_RESPONSE;
                    end
                end
            end
            TYPE_RST: begin
                if (m.id == cfg_req_id)
                    c.action = ACT_RESET;
            end
            TYPE_CON: begin
                if (!token_hit(m.token, m.token_len)) begin
                    c.action = ACT_ACK_ONLY;
                end else if (last_con_ok && last_con_id == m.id) begin
                    c.action = ACT_ACK_ONLY;
                end else begin
                    last_con_id = m.id;
                    last_con_ok = 1'b1;
                    c.action = ACT_RESPONSE_ACK;
                end
            end
            default: begin
                if (token_hit(m.token, m.token_len))
                    c.action = ACT_RESPONSE;
            end
        endcase
        c.separate = sep_seen;
        return c;
    endfunction

    function automatic t_msg hdr(input t_msg_type ty, input logic [7:0] code,
                                 input logic [15:0] id, input logic [63:0] tok,
                                 input logic [3:0] len);
        t_msg m;
        m.msg_type  = ty;
        m.code      = code;
        m.id        = id;
        m.token     = tok;
        m.token_len = len;
        return m;
    endfunction

    // mostly well-formed requests against the current setting, plus near misses and noise
    function automatic t_msg make_msg(input logic [15:0] id_base);
        t_msg        m;
        int          pick;
        int          bitpos;
        logic [63:0] mask;
        logic [63:0] rnd;
        pick = $urandom_range(0, 99);
        rnd  = {$urandom, $urandom};
        mask = len_mask(cfg_token_len);
        m.msg_type  = TYPE_NON;
        m.code      = 8'($urandom_range(0, 255));
        m.id        = 16'($urandom_range(0, 65535));
        m.token     = (cfg_token & mask) | (rnd & ~mask);
        m.token_len = cfg_token_len;
        if (pick < 30) begin
            m.msg_type = TYPE_CON;
            m.id = id_base + 16'($urandom_range(0, 3));
        end else if (pick < 42) begin
            m.msg_type = TYPE_NON;
        end else if (pick < 65) begin
            m.msg_type = TYPE_ACK;
            if ($urandom_range(0, 9) != 0)
                m.id = cfg_req_id;
            if ($urandom_range(0, 2) == 0)
                m.code = CODE_EMPTY;
        end else if (pick < 75) begin
            m.msg_type = TYPE_RST;
            if ($urandom_range(0, 1) != 0)
                m.id = cfg_req_id;
            m.token     = {$urandom, $urandom};
            m.token_len = 4'($urandom_range(0, 15));
        end else if (pick < 87) begin
            m.msg_type = t_msg_type'($urandom_range(0, 3));
            if ($urandom_range(0, 1) != 0)
                m.id = cfg_req_id;
            if (cfg_token_len != 0 && $urandom_range(0, 1) != 0) begin
                bitpos = $urandom_range(0, 8 * cfg_token_len - 1);
                m.token[bitpos] = ~m.token[bitpos];
            end else begin
                m.token_len = 4'($urandom_range(0, 15));
            end
        end else begin
            m.msg_type  = t_msg_type'($urandom_range(0, 3));
            m.token     = rnd;
            m.token_len = 4'($urandom_range(0, 15));
        end
        return m;
    endfunction

    task automatic set_reg(input logic [1:0] idx, input logic [63:0] data);
        logic [3:0] len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_REQUEST_ID:     cfg_req_id = data[15:0];
            REG_EXPECTED_TOKEN: cfg_token = data;
            REG_EXPECTED_TOKEN_LEN: begin
                len = data[3:0];
                cfg_token_len = (len > TOKEN_BYTES) ? 4'(TOKEN_BYTES) : len;
            end
            default: ;
        endcase
        if (idx != REG_NONE) begin
            last_con_id = '0;
            last_con_ok = 1'b0;
            sep_seen    = 1'b0;
        end
    endtask

    // hold until every request is in and every classification is out
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (msg_q.size() != 0 || have_item || class_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            have_item = 1'b0;
            src_gap   = 0;
        end else begin
            if (have_item && i_valid && o_ready) begin
                class_q.push_back(classify_msg(cur_msg));
                have_item = 1'b0;
                src_gap = calm ? 0 : $urandom_range(0, 5);
            end
            if (!have_item && src_gap > 0) begin
                src_gap--;
            end else if (!have_item && msg_q.size() != 0) begin
                cur_msg   = msg_q.pop_front();
                have_item = 1'b1;
            end
            i_valid         <= have_item;
            i_msg_type      <= cur_msg.msg_type;
            i_msg_code      <= cur_msg.code;
            i_msg_id        <= cur_msg.id;
            i_msg_token     <= cur_msg.token;
            i_msg_token_len <= cur_msg.token_len;
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_class want;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            sink_gap  = 0;
            hold_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (class_q.size() == 0) begin
                    $error("result with no request pending: action %0d", o_action);
                    errors++;
                end else begin
                    want = class_q.pop_front();
                    if (o_action !== want.action) begin
                        $error("action: expected %0d, got %0d", want.action, o_action);
                        errors++;
                    end
                    if (o_separate_pending !== want.separate) begin
                        $error("separate_pending: expected %0d, got %0d",
                               want.separate, o_separate_pending);
                        errors++;
                    end
                end
                sink_gap = calm ? 0 : $urandom_range(0, 5);
            end
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
                stuck = 0;
            end else begin
                stuck++;
                if (stuck >= IDLE_LIMIT) begin
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [63:0] tok;
        logic [63:0] rnd;
        logic [15:0] id_base;
        logic [15:0] rid;
        logic [3:0]  len_code [8];
        len_code = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd9, 4'd4, 4'd7, 4'd12};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-ones request ID, full-length token
        tok = {$urandom, $urandom};
        rnd = {$urandom, $urandom};
        set_reg(REG_REQUEST_ID, {rnd[63:16], 16'hFFFF});
        set_reg(REG_EXPECTED_TOKEN, tok);
        set_reg(REG_EXPECTED_TOKEN_LEN, 64'd8);
        msg_q.push_back(hdr(TYPE_NON, 8'h45, 16'h1234, tok, 4'd8));
        msg_q.push_back(hdr(TYPE_NON, 8'h45, 16'h1234, tok ^ 64'hFF00_0000_0000_0000, 4'd8));
        msg_q.push_back(hdr(TYPE_CON, 8'h02, 16'd5, tok, 4'd8));
        msg_q.push_back(hdr(TYPE_CON, 8'h02, 16'd5, tok, 4'd8));       // duplicate
        msg_q.push_back(hdr(TYPE_CON, 8'h02, 16'd6, ~tok, 4'd8));      // foreign token
        msg_q.push_back(hdr(TYPE_CON, 8'hFF, 16'd0, tok, 4'd8));
        msg_q.push_back(hdr(TYPE_ACK, CODE_EMPTY, 16'hFFFF, ~tok, 4'd15));
        msg_q.push_back(hdr(TYPE_ACK, 8'h45, 16'hFFFF, tok, 4'd8));
        msg_q.push_back(hdr(TYPE_ACK, 8'hFF, 16'hFFFF, tok ^ 64'd1, 4'd8));
        msg_q.push_back(hdr(TYPE_ACK, CODE_EMPTY, 16'hFFFE, tok, 4'd8));
        msg_q.push_back(hdr(TYPE_RST, 8'hFF, 16'hFFFF, ~tok, 4'd15));
        msg_q.push_back(hdr(TYPE_RST, CODE_EMPTY, 16'd0, tok, 4'd8));
        msg_q.push_back(hdr(TYPE_NON, 8'h45, 16'hFFFF, tok, 4'd15));   // long length
        msg_q.push_back(hdr(TYPE_NON, 8'h45, 16'hFFFF, tok, 4'd9));
        wait_idle();

        // a write to an unused index keeps the marks
        set_reg(REG_NONE, {$urandom, $urandom});
        msg_q.push_back(hdr(TYPE_CON, 8'h01, 16'd0, tok, 4'd8));
        msg_q.push_back(hdr(TYPE_ACK, 8'h44, 16'hFFFF, tok, 4'd8));
        wait_idle();

        // zero-length token matches only a zero-length request token
        set_reg(REG_EXPECTED_TOKEN_LEN, 64'hFFFF_FFFF_FFFF_FFF0);
        msg_q.push_back(hdr(TYPE_NON, 8'h45, 16'h0, '1, 4'd0));
        msg_q.push_back(hdr(TYPE_NON, 8'h45, 16'h0, tok, 4'd1));
        msg_q.push_back(hdr(TYPE_CON, 8'h01, 16'd0, '0, 4'd0));
        wait_idle();

        // a length above the token size clamps
        set_reg(REG_EXPECTED_TOKEN_LEN, 64'd15);
        msg_q.push_back(hdr(TYPE_NON, 8'h45, 16'h0, tok, 4'd8));
        msg_q.push_back(hdr(TYPE_NON, 8'h45, 16'h0, tok, 4'd15));

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            rid = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom);
            tok = (p == 0) ? 64'd0 : (p == 1) ? '1 : {$urandom, $urandom};
            rnd = {$urandom, $urandom};
            if (p % 2 == 1) begin
                set_reg(REG_EXPECTED_TOKEN, tok);
                set_reg(REG_EXPECTED_TOKEN_LEN, {rnd[63:4], len_code[p]});
                set_reg(REG_REQUEST_ID, {rnd[47:0], rid});
            end else begin
                set_reg(REG_REQUEST_ID, {rnd[47:0], rid});
                set_reg(REG_EXPECTED_TOKEN, tok);
                set_reg(REG_EXPECTED_TOKEN_LEN, {rnd[63:4], len_code[p]});
            end
            if (p == 4)
                set_reg(REG_NONE, {$urandom, $urandom});
            calm = (p == 3 || p == 6);
            if (p == 2)
                hold_ask++;
            // wrap the CON ID window over the top of the range once
            id_base = (p == 5) ? 16'hFFFE : 16'($urandom);
            repeat (PHASE_ITEMS) msg_q.push_back(make_msg(id_base));
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
